FILE: src/cordic_rotate_vector_assert.svh
// Assertion macros shared by the checker.
`ifndef CORDIC_ROTATE_VECTOR_ASSERT_SVH
`define CORDIC_ROTATE_VECTOR_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define CRV_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("cordic_rotate_vector assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define CRV_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("cordic_rotate_vector assertion failed");

`endif

FILE: src/crv_pkg.sv
package crv_pkg;

    localparam int ITERATIONS     = 14;
    localparam int DATA_FRAC_BITS = 13;
    localparam int ACC_FRAC_BITS  = 30;
    localparam int ACC_INT_BITS   = 5;

    localparam int DATA_W   = 16;
    localparam int ACC_W    = ACC_INT_BITS + ACC_FRAC_BITS;
    localparam int FRAC_GAP = ACC_FRAC_BITS - DATA_FRAC_BITS;
    localparam int WIDE_W   = ACC_W + DATA_W;
    localparam int STAGE_W  = (ITERATIONS > 1) ? $clog2(ITERATIONS) : 1;

    typedef logic signed [DATA_W-1:0] data_t;
    typedef logic signed [ACC_W-1:0]  acc_t;
    typedef logic [STAGE_W-1:0]       stage_t;
    typedef logic [ITERATIONS-1:0][ACC_W-1:0] atan_tab_t;

    typedef struct packed {
        data_t x_in;
        data_t y_in;
        data_t phase;
        logic  mode;
        logic  last_in;
    } crv_in_t;

    typedef struct packed {
        data_t x_out;
        data_t y_out;
        data_t z_out;
        logic  last_out;
    } crv_out_t;

    // Working state carried down the cell chain.
    typedef struct packed {
        acc_t x;
        acc_t y;
        acc_t z;
        logic mode;
        logic last;
    } crv_data_t;

    // atan(2^-i), truncated to ACC_FRAC_BITS fraction bits. Elaboration only.
    function automatic atan_tab_t calc_atan_tab();
        atan_tab_t tab;
        real       a;
        for (int i = 0; i < ITERATIONS; i++)
        begin
            a      = $floor($atan(2.0 ** (-i)) * (2.0 ** ACC_FRAC_BITS));
            tab[i] = ACC_W'(longint'(a));
        end
        return tab;
    endfunction

    localparam atan_tab_t ATAN_TAB = calc_atan_tab();

    // 16-bit fixed point into accumulator format; wraps on overflow.
    function automatic acc_t widen(data_t v);
        logic signed [WIDE_W-1:0] w;
        w = WIDE_W'(v);
        w = w <<< FRAC_GAP;
        return w[ACC_W-1:0];
    endfunction

    // Drop extra fraction bits (floor), wrap to 16 bits.
    function automatic data_t narrow(acc_t v);
        logic signed [WIDE_W-1:0] w;
        w = WIDE_W'(v);
        w = w >>> FRAC_GAP;
        return w[DATA_W-1:0];
    endfunction

endpackage

FILE: src/crv_cell.sv
module crv_cell (
    input  logic               clk,
    input  logic               rst_n,
    input  crv_pkg::stage_t    stage,
    input  logic               up_valid,
    output logic               up_ready,
    input  crv_pkg::crv_data_t up_data,
    output logic               dn_valid,
    input  logic               dn_ready,
    output crv_pkg::crv_data_t dn_data
);
    import crv_pkg::*;

    logic      vld_reg;
    crv_data_t data_reg;
    crv_data_t data_next;
    acc_t      xs;
    acc_t      ys;
    acc_t      ang;
    logic      pos;

    // Stage can take a beat when empty or when its content moves on.
    assign up_ready = !vld_reg || dn_ready;

    always_comb
    begin
        xs  = up_data.x >>> stage;
        ys  = up_data.y >>> stage;
        ang = acc_t'(ATAN_TAB[stage]);
        // vectoring steers by y, rotation by z (zero counts as positive)
        pos = up_data.mode ? up_data.y[ACC_W-1] : !up_data.z[ACC_W-1];
        data_next      = up_data;
        data_next.x    = pos ? (up_data.x - ys)  : (up_data.x + ys);
        data_next.y    = pos ? (up_data.y + xs)  : (up_data.y - xs);
        data_next.z    = pos ? (up_data.z - ang) : (up_data.z + ang);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else if (up_ready)
        begin
            vld_reg <= up_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (up_valid && up_ready)
        begin
            data_reg <= data_next;
        end
    end

    assign dn_valid = vld_reg;
    assign dn_data  = data_reg;

endmodule

FILE: src/cordic_rotate_vector.sv
// Channel   Signals                                    Direction  Beat
// sample    sample_valid / sample_ready / sample       in         x, y, phase, mode, last
// result    result_valid / result_ready / result       out        x, y, z, last
//
// Pipeline: one register per micro-rotation cell; the last cell is the output register.
// Throughput: one beat per cycle while result_ready is high; ready ripples
//   back through the cells.
// Stalls: a cell holds its beat while downstream is full; empty cells
//   still fill, so bubbles collapse and sample_ready stays high until full.
// Reset: clears only the valid bits of the cells; data registers are not reset.
module cordic_rotate_vector (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              sample_valid,
    output logic              sample_ready,
    input  crv_pkg::crv_in_t  sample,
    output logic              result_valid,
    input  logic              result_ready,
    output crv_pkg::crv_out_t result
);
    import crv_pkg::*;

    // Index k is the input side of cell k; index ITERATIONS is the output.
    logic      valid [ITERATIONS+1];
    logic      ready [ITERATIONS+1];
    crv_data_t data  [ITERATIONS+1];

    // Widen into accumulator format on entry; no gain compensation anywhere.
    always_comb
    begin
        data[0].x    = widen(sample.x_in);
        data[0].y    = widen(sample.y_in);
        data[0].z    = widen(sample.phase);
        data[0].mode = sample.mode;
        data[0].last = sample.last_in;
    end

    assign valid[0]     = sample_valid;
    assign sample_ready = ready[0];

    // One cell per micro-rotation; cell k shifts by k and uses atan(2^-k).
    for (genvar k = 0; k < ITERATIONS; k++)
    begin : g_cell
        crv_cell u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .stage    (STAGE_W'(k)),
            .up_valid (valid[k]),
            .up_ready (ready[k]),
            .up_data  (data[k]),
            .dn_valid (valid[k+1]),
            .dn_ready (ready[k+1]),
            .dn_data  (data[k+1])
        );
    end

    assign ready[ITERATIONS] = result_ready;
    assign result_valid      = valid[ITERATIONS];

    // Narrowing is bit selection only: floor, then wrap to 16 bits.
    always_comb
    begin
        result.x_out    = narrow(data[ITERATIONS].x);
        result.y_out    = narrow(data[ITERATIONS].y);
        result.z_out    = narrow(data[ITERATIONS].z);
        result.last_out = data[ITERATIONS].last;
    end

endmodule

FILE: src/crv_checker.sv
`include "cordic_rotate_vector_assert.svh"

module crv_checker (
    input logic              clk,
    input logic              rst_n,
    input logic              sample_valid,
    input logic              sample_ready,
    input crv_pkg::crv_in_t  sample,
    input logic              result_valid,
    input logic              result_ready,
    input crv_pkg::crv_out_t result
);
    import crv_pkg::*;

    localparam int RUN_W = $clog2(ITERATIONS + 1) + 1;

    logic [RUN_W-1:0] run_reg;
    logic [RUN_W-1:0] run_next;
    logic             run_full;
    logic             sample_beat;

    // Consecutive cycles with result_ready high, saturating.
    assign run_full    = (run_reg >= RUN_W'(ITERATIONS));
    assign run_next    = !result_ready ? '0 : (run_full ? run_reg : run_reg + 1'b1);
    assign sample_beat = sample_valid && sample_ready && rst_n && (sample.mode || !sample.mode);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg <= '0;
        end
        else
        begin
            run_reg <= run_next;
        end
    end

    `CRV_ASSERT_NEXT(a_result_held, clk, rst_n, result_valid && !result_ready, result_valid)
    `CRV_ASSERT_NEXT(a_result_stable, clk, rst_n, result_valid && !result_ready, $stable(result))
    `CRV_ASSERT_IMPLY(a_ready_when_drain, clk, rst_n, result_ready || !result_valid, sample_ready)
    `CRV_ASSERT_IMPLY(a_fixed_latency, clk, rst_n, (run_reg >= RUN_W'(ITERATIONS - 1)) && $past(sample_beat, ITERATIONS), result_valid)

endmodule

bind cordic_rotate_vector crv_checker u_crv_checker (.*);

FILE: verif/testbench.sv
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    // Steering mode carried in each sample beat.
    localparam logic MODE_ROTATE = 1'b0;
    localparam logic MODE_VECTOR = 1'b1;

    // Fraction bits used for the exact arctangent series.
    localparam int SERIES_BITS = 60;

    // Receiver hold-off used to fill the pipe and force sample_ready low.
    localparam int HOLD_CYCLES = 80;

    // Cycle budget. A clean run covers ~1550 beats, idling on each side,
    // the pipe and one hold.
    localparam int CYCLE_LIMIT = 200000;

    localparam int RANDOM_BEATS   = 1490;
    localparam int PRESSURE_BEATS = 48;
    localparam int CALM_FIRST     = 600;
    localparam int CALM_LAST      = 799;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic               sample_valid = 1'b0;
    logic               sample_ready;
    crv_pkg::crv_in_t   sample = '0;
    logic               result_valid;
    logic               result_ready = 1'b0;
    crv_pkg::crv_out_t  result;

    cordic_rotate_vector u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .sample_valid (sample_valid),
        .sample_ready (sample_ready),
        .sample       (sample),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

    // Half period of 1 ns gives the 2 ns clock.
    always #1 clk = ~clk;

    // atan(2^-i) with ACC_FRAC_BITS fraction bits, truncated.
    crv_pkg::acc_t atan_lut [crv_pkg::ITERATIONS];

    // Expected result beats, oldest first.
    crv_pkg::crv_out_t pending_results [$];

    int errors          = 0;
    int results_checked = 0;
    int rotate_beats    = 0;
    int vector_beats    = 0;
    int last_beats      = 0;
    int stall_cycles    = 0;
    int cycles          = 0;

    // Idling control. calm_tx is read only by the sender code in the
    // initial block; calm_rx and hold_req go to the receiver process.
    logic calm_tx = 1'b0;
    logic calm_rx = 1'b0;
    int   hold_req  = 0;
    int   hold_seen = 0;
    int   hold_left = 0;

    // ------------------------------------------------------------------
    // Arctangent table, built exactly from integer series.
    // ------------------------------------------------------------------

    // atan(1/n) with SERIES_BITS fraction bits, n >= 2.
    function automatic longint unsigned atan_recip(longint unsigned n);
        longint unsigned p;
        longint unsigned n2;
        longint unsigned sum;
        longint unsigned term;
        longint unsigned k;
        p   = (64'd1 << SERIES_BITS) / n;
        n2  = n * n;
        sum = 0;
        k   = 0;
        while (p != 0)
        begin
            term = p / (2 * k + 1);
            if ((k % 2) == 0)
                sum = sum + term;
            else
                sum = sum - term;
            p = p / n2;
            k = k + 1;
        end
        return sum;
    endfunction

    function automatic void build_atan_lut();
        longint unsigned v;
        for (int i = 0; i < crv_pkg::ITERATIONS; i++)
        begin
            // Machin's formula for pi/4, plain series for the rest.
            if (i == 0)
                v = 4 * atan_recip(5) - atan_recip(239);
            else
                v = atan_recip(64'd1 << i);
            atan_lut[i] = crv_pkg::acc_t'(v >> (SERIES_BITS - crv_pkg::ACC_FRAC_BITS));
        end
    endfunction

    // ------------------------------------------------------------------
    // CORDIC prediction.
    // ------------------------------------------------------------------

    // 16-bit fixed point up to accumulator format.
    function automatic crv_pkg::acc_t to_acc(crv_pkg::data_t v);
        crv_pkg::acc_t a;
        a = v;
        return a <<< crv_pkg::FRAC_GAP;
    endfunction

    // Floor the extra fraction bits away, keep the low 16 bits (wraps).
    function automatic crv_pkg::data_t from_acc(crv_pkg::acc_t a);
        crv_pkg::acc_t t;
        t = a >>> crv_pkg::FRAC_GAP;
        return t[crv_pkg::DATA_W-1:0];
    endfunction

    function automatic crv_pkg::crv_out_t cordic_result(crv_pkg::crv_in_t s);
        crv_pkg::acc_t     x;
        crv_pkg::acc_t     y;
        crv_pkg::acc_t     z;
        crv_pkg::acc_t     xs;
        crv_pkg::acc_t     ys;
        logic              ccw;
        crv_pkg::crv_out_t r;
        x = to_acc(s.x_in);
        y = to_acc(s.y_in);
        z = to_acc(s.phase);
        for (int i = 0; i < crv_pkg::ITERATIONS; i++)
        begin
            xs = x >>> i;
            ys = y >>> i;
            // Rotation: z >= 0 steers positive. Vectoring: y < 0 does.
            if (s.mode == MODE_VECTOR)
                ccw = y[crv_pkg::ACC_W-1];
            else
                ccw = ~z[crv_pkg::ACC_W-1];
            if (ccw)
            begin
                x = x - ys;
                y = y + xs;
                z = z - atan_lut[i];
            end
            else
            begin
                x = x + ys;
                y = y - xs;
                z = z + atan_lut[i];
            end
        end
        r.x_out    = from_acc(x);
        r.y_out    = from_acc(y);
        r.z_out    = from_acc(z);
        r.last_out = s.last_in;
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Beat construction.
    // ------------------------------------------------------------------

    function automatic crv_pkg::crv_in_t make_sample(int x, int y, int phase,
                                                     logic mode, logic last);
        crv_pkg::crv_in_t s;
        s.x_in    = crv_pkg::data_t'(x);
        s.y_in    = crv_pkg::data_t'(y);
        s.phase   = crv_pkg::data_t'(phase);
        s.mode    = mode;
        s.last_in = last;
        return s;
    endfunction

    // Full-scale corners and the values around zero.
    function automatic crv_pkg::data_t corner_value();
        case ($urandom_range(4))
            0: return crv_pkg::data_t'(-32768);
            1: return crv_pkg::data_t'(32767);
            2: return crv_pkg::data_t'(0);
            3: return crv_pkg::data_t'(-1);
            default: return crv_pkg::data_t'(1);
        endcase
    endfunction

    // Mostly full-range fields; some within +-1.0 where results stay in
    // range, some at the corners where the outputs wrap.
    function automatic crv_pkg::data_t random_field();
        int pick;
        pick = $urandom_range(99);
        if (pick < 60)
            return crv_pkg::data_t'($urandom);
        else if (pick < 85)
            return crv_pkg::data_t'($urandom_range(16384) - 8192);
        else
            return corner_value();
    endfunction

    function automatic crv_pkg::crv_in_t random_sample();
        crv_pkg::crv_in_t s;
        s.x_in    = random_field();
        s.y_in    = random_field();
        s.phase   = random_field();
        s.mode    = ($urandom_range(1) == 1) ? MODE_VECTOR : MODE_ROTATE;
        s.last_in = 1'($urandom_range(1));
        return s;
    endfunction

    // ------------------------------------------------------------------
    // Sender: one beat per call, entered and left at a rising edge.
    // ------------------------------------------------------------------

    task automatic send_sample(crv_pkg::crv_in_t s);
        // Idle about 23% of cycles unless in a calm stretch.
        while (!calm_tx && $urandom_range(99) < 23)
        begin
            sample_valid <= 1'b0;
            @(posedge clk);
        end
        sample       <= s;
        sample_valid <= 1'b1;
        // Ready only moves at rising edges, so the falling edge shows what
        // the next rising edge will see.
        do
            @(negedge clk);
        while (!sample_ready);
        @(posedge clk);
    endtask

    // ------------------------------------------------------------------
    // Receiver: random ready, calm stretches, and a counted hold-off.
    // ------------------------------------------------------------------

    always @(posedge clk)
    begin
        if (hold_seen != hold_req)
        begin
            hold_seen    <= hold_req;
            hold_left    <= HOLD_CYCLES - 1;
            result_ready <= 1'b0;
        end
        else if (hold_left != 0)
        begin
            hold_left    <= hold_left - 1;
            result_ready <= 1'b0;
        end
        else if (calm_rx)
            result_ready <= 1'b1;
        else
            result_ready <= ($urandom_range(99) >= 23);
    end

    // ------------------------------------------------------------------
    // Monitors, sampled mid-cycle where both channels are stable.
    // ------------------------------------------------------------------

    always @(negedge clk)
    begin
        if (rst_n && sample_valid)
        begin
            if (sample_ready)
            begin
                pending_results.push_back(cordic_result(sample));
                if (sample.mode == MODE_VECTOR)
                    vector_beats++;
                else
                    rotate_beats++;
                if (sample.last_in)
                    last_beats++;
            end
            else
                stall_cycles++;
        end
    end

    always @(negedge clk)
    begin : check_result
        crv_pkg::crv_out_t want;
        if (rst_n && result_valid && result_ready)
        begin
            if (pending_results.size() == 0)
            begin
                $error("result beat with nothing outstanding: x=%0d y=%0d z=%0d last=%0b",
                       result.x_out, result.y_out, result.z_out, result.last_out);
                errors++;
            end
            else
            begin
                want = pending_results.pop_front();
                results_checked++;
                if (result.x_out !== want.x_out)
                begin
                    $error("x_out: expected %0d, got %0d", want.x_out, result.x_out);
                    errors++;
                end
                if (result.y_out !== want.y_out)
                begin
                    $error("y_out: expected %0d, got %0d", want.y_out, result.y_out);
                    errors++;
                end
                if (result.z_out !== want.z_out)
                begin
                    $error("z_out: expected %0d, got %0d", want.z_out, result.z_out);
                    errors++;
                end
                if (result.last_out !== want.last_out)
                begin
                    $error("last_out: expected %0b, got %0b",
                           want.last_out, result.last_out);
                    errors++;
                end
            end
        end
    end

    // Watchdog.
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT)
        begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Tests.
    // ------------------------------------------------------------------

    // x and y at full-scale corners, phase at corners or near zero, in both
    // modes; outputs wrap here since the unscaled gain pushes |x|,|y| past 4.0.
    task automatic test_field_corners();
        for (int m = 0; m < 2; m++)
        begin
            send_sample(make_sample(32767, 32767, 32767, logic'(m), 1'b1));
            send_sample(make_sample(-32768, -32768, -32768, logic'(m), 1'b0));
            send_sample(make_sample(32767, -32768, 0, logic'(m), 1'b1));
            send_sample(make_sample(-32768, 32767, -1, logic'(m), 1'b0));
        end
    endtask

    // Steering ties and quarter turns: z == 0 counts as positive in
    // rotation, y == 0 counts as non-negative in vectoring.
    task automatic test_steering_ties();
        send_sample(make_sample(8192, 0, 0, MODE_ROTATE, 1'b0));
        send_sample(make_sample(8192, 0, -1, MODE_ROTATE, 1'b1));
        send_sample(make_sample(8192, 0, 12868, MODE_ROTATE, 1'b0));
        send_sample(make_sample(8192, 0, -12868, MODE_ROTATE, 1'b1));
        send_sample(make_sample(8192, 0, 0, MODE_VECTOR, 1'b0));
        send_sample(make_sample(-8192, 0, 0, MODE_VECTOR, 1'b1));
        send_sample(make_sample(0, -1, 0, MODE_VECTOR, 1'b0));
        send_sample(make_sample(0, 8192, 25736, MODE_VECTOR, 1'b1));
        send_sample(make_sample(0, 0, 0, MODE_ROTATE, 1'b0));
        send_sample(make_sample(0, 0, 0, MODE_VECTOR, 1'b1));
    endtask

    // Receiver runs its hold-off while the sender keeps offering back
    // to back, so the pipe fills and sample_ready has to drop.
    task automatic test_back_pressure();
        calm_tx = 1'b1;
        hold_req <= hold_req + 1;
        for (int n = 0; n < PRESSURE_BEATS; n++)
            send_sample(random_sample());
        calm_tx = 1'b0;
    endtask

    // Random stream with idling on both sides, plus one stretch where
    // neither side idles.
    task automatic test_random_stream();
        for (int n = 0; n < RANDOM_BEATS; n++)
        begin
            if (n == CALM_FIRST)
            begin
                calm_tx = 1'b1;
                calm_rx <= 1'b1;
            end
            else if (n == CALM_LAST + 1)
            begin
                calm_tx = 1'b0;
                calm_rx <= 1'b0;
            end
            send_sample(random_sample());
        end
    endtask

    initial
    begin
        build_atan_lut();

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_field_corners();
        test_steering_ties();
        test_back_pressure();
        test_random_stream();

        sample_valid <= 1'b0;

        // Drain, then give the pipe time to show any stray beats.
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (2 * crv_pkg::ITERATIONS) @(posedge clk);

        $display("Sent %0d beats (%0d rotation, %0d vectoring, %0d with last set).",
                 rotate_beats + vector_beats, rotate_beats, vector_beats, last_beats);
        $display("Checked %0d results; input stalled %0d cycles; %0d mismatches.",
                 results_checked, stall_cycles, errors);
        if (errors == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
